// File: hdl/rmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Shared constants, types and the CRC-16 byte update used by the framer.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int FrameLen = 8;
   localparam int HeaderLen = 6;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW = $clog2(QueueDepth);
   localparam int QueueCntW = $clog2(QueueDepth + 1);
   localparam int ByteIdxW = $clog2(FrameLen);

   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [7:0] FnRead = 8'h03;
   localparam logic [7:0] FnWrite = 8'h06;
   localparam logic [15:0] ReadQty = 16'h0001;
   localparam logic [7:0] SlaveAddrReset = 8'h01;

   localparam logic ActRead = 1'b0;
   localparam logic ActWrite = 1'b1;

   localparam logic [ByteIdxW-1:0] IdxCrcLo = ByteIdxW'(6);
   localparam logic [ByteIdxW-1:0] IdxCrcHi = ByteIdxW'(7);

   typedef logic [HeaderLen-1:0][7:0] rmf_header_type;

   typedef struct packed {
      logic valid;
      rmf_header_type header;
   } rmf_push_type;

   typedef struct packed {
      logic valid;
      rmf_header_type header;
   } rmf_head_type;

   function automatic logic [15:0] rmf_crc_byte(input logic [15:0] crc,
                                                input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage : rmf_pkg
`default_nettype wire

// File: hdl/rmf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Framer front end
// Accepts requests, decodes read or write and builds the six header bytes.
// ----------------------------------------------------------------------------
module rmf_front
   import rmf_pkg::*;
(
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic         req_tuser,   // action
   input  wire logic [31:0]  req_tdata,   // register_address[15:0],
                                          // register_value[31:16]
   input  wire logic [7:0]   dev_address,
   input  wire logic         queue_full,
   output rmf_push_type      push
);

   logic        action;
   logic [15:0] reg_addr;
   logic [15:0] reg_value;
   logic [15:0] word_4;

   assign action = req_tuser;
   assign reg_addr = req_tdata[15:0];
   assign reg_value = req_tdata[31:16];

   assign req_tready = !queue_full;

   always_comb begin
      word_4 = ReadQty;
      push.header[1] = FnRead;
      unique case (action)
         ActWrite: begin
            word_4 = reg_value;
            push.header[1] = FnWrite;
         end
         ActRead: begin
            word_4 = ReadQty;
            push.header[1] = FnRead;
         end
         default: begin
            word_4 = ReadQty;
            push.header[1] = FnRead;
         end
      endcase
      push.valid = req_tvalid && !queue_full;
      push.header[0] = dev_address;
      push.header[2] = reg_addr[15:8];
      push.header[3] = reg_addr[7:0];
      push.header[4] = word_4[15:8];
      push.header[5] = word_4[7:0];
   end

endmodule : rmf_front
`default_nettype wire

// File: hdl/rmf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Framer header queue
// Short FIFO of built headers between the front end and the byte sender.
// ----------------------------------------------------------------------------
module rmf_queue
   import rmf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  rmf_push_type  push,
   input  wire logic     pop,
   output logic          full,
   output rmf_head_type  head
);

   rmf_header_type         mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign full = (count_ff == QueueCntW'(QueueDepth));
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.header;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.header = mem_ff[rd_ptr_ff];

endmodule : rmf_queue
`default_nettype wire

// File: hdl/rmf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Framer byte sender
// Sends the header bytes one per cycle while rsp_tready is high, folds each
// into the CRC and appends the CRC low byte first, marking the final byte.
// ----------------------------------------------------------------------------
module rmf_back
   import rmf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  rmf_head_type      head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // frame_byte[7:0]
   output logic              rsp_tlast
);

   logic [ByteIdxW-1:0] idx_ff, idx_in;
   logic [15:0]         crc_ff, crc_in;
   logic                valid_ff, valid_in;
   logic [7:0]          data_ff, data_in;
   logic                last_ff, last_in;
   logic                load;
   logic [7:0]          next_byte;
   logic [15:0]         crc_base;

   assign load = head.valid && (!valid_ff || rsp_tready);
   assign pop = load && (idx_ff == IdxCrcHi);
   assign crc_base = (idx_ff == '0) ? CrcInit : crc_ff;

   always_comb begin
      unique case (idx_ff)
         IdxCrcLo: next_byte = crc_ff[7:0];
         IdxCrcHi: next_byte = crc_ff[15:8];
         default:  next_byte = head.header[idx_ff];
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      crc_in = crc_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in = data_ff;
      last_in = last_ff;
      if (load) begin
         idx_in = (idx_ff == IdxCrcHi) ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
         data_in = next_byte;
         last_in = (idx_ff == IdxCrcHi);
         if (idx_ff < IdxCrcLo) begin
            crc_in = rmf_crc_byte(crc_base, next_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;

endmodule : rmf_back
`default_nettype wire

// File: hdl/modbus_rtu_request_framer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns each read or write request into an eight-byte Modbus RTU frame with
// its CRC-16 appended.
// ----------------------------------------------------------------------------
// Each request yields eight bytes on the rsp stream, one per cycle while
// rsp_tready is high. The first byte passes through the header queue and
// then the single-byte output register, and the two-entry header queue
// lets one further request be taken while a frame is still being sent.
// The slave address is
// sampled when the request is taken.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_unit
   import rmf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic         req_tuser,   // action
   input  wire logic [31:0]  req_tdata,   // register_address[15:0],
                                          // register_value[31:16]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // frame_byte[7:0]
   output logic              rsp_tlast,   // last_byte
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [7:0]    dev_addr_ff, dev_addr_in;
   logic          csr_write;
   logic          queue_full;
   logic          pop;
   rmf_push_type  push;
   rmf_head_type  head;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      dev_addr_in = dev_addr_ff;
      if (csr_write && !csr_paddr[2]) begin
         dev_addr_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= SlaveAddrReset;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'h0 : {24'h0, dev_addr_ff};

   rmf_front u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .dev_address   (dev_addr_ff),
      .queue_full    (queue_full),
      .push          (push)
   );

   rmf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   rmf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule : modbus_rtu_request_framer_unit
`default_nettype wire

// File: hdl/rmf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Framer port checker
// Watches the top-level ports for frame structure and stream behavior.
// ----------------------------------------------------------------------------
module rmf_checker
   import rmf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [7:0]   rsp_tdata,
   input  wire logic         rsp_tlast
);

   logic [ByteIdxW-1:0] pos_ff, pos_in;
   logic                rsp_take;

   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      pos_in = pos_ff;
      if (rsp_take) begin
         pos_in = rsp_tlast ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled response changed");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (pos_ff == IdxCrcHi)))
      else $error("tlast not on the eighth byte");

   a_function_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (pos_ff == ByteIdxW'(1))) |->
         (rsp_tdata == FnRead || rsp_tdata == FnWrite))
      else $error("bad function code");

endmodule : rmf_checker

bind modbus_rtu_request_framer_unit rmf_checker u_rmf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// File: tb/tb_modbus_rtu_request_framer_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the Modbus RTU request framer
// Read and write requests are streamed into the block. A scoreboard builds
// each expected eight-byte frame, including the CRC-16, and compares the
// frame bytes and the last-byte flag as they leave. The slave address is
// reprogrammed between phases, and the sender and receiver idle at
// different rates, with one long receiver stall.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_request_framer_unit;
   import rmf_pkg::*;

   localparam logic [2:0] SlaveAddrOfs = 3'd0;
   localparam logic [2:0] UnusedOfs = 3'd4;
   localparam logic [7:0] SlaveAddrDefault = 8'h01;
   localparam logic [7:0] FuncReadHolding = 8'h03;
   localparam logic [7:0] FuncWriteSingle = 8'h06;
   localparam logic [15:0] ReadQuantity = 16'h0001;
   localparam logic [15:0] ModbusCrcInit = 16'hFFFF;
   localparam logic [15:0] ModbusCrcPoly = 16'hA001;

   typedef struct packed {
      logic [7:0] data;
      logic last;
   } frame_octet_type;

   class frame_scoreboard;
      frame_octet_type expected_octets[$];
      logic [7:0] dev_addr;
      int unsigned mismatches;

      function new();
         dev_addr = SlaveAddrDefault;
         mismatches = 0;
      endfunction

      function void set_dev_address(logic [7:0] addr);
         dev_addr = addr;
      endfunction

      function int pending();
         return expected_octets.size();
      endfunction

      // Builds the frame for one accepted request and queues its bytes.
      function void note_request(logic act, logic [15:0] reg_addr, logic [15:0] reg_val);
         logic [7:0] frame [8];
         logic [15:0] crc;
         logic [15:0] payload;
         frame_octet_type octet;
         payload = (act == ActWrite) ? reg_val : ReadQuantity;
         frame[0] = dev_addr;
         frame[1] = (act == ActWrite) ? FuncWriteSingle : FuncReadHolding;
         frame[2] = reg_addr[15:8];
         frame[3] = reg_addr[7:0];
         frame[4] = payload[15:8];
         frame[5] = payload[7:0];
         crc = ModbusCrcInit;
         for (int k = 0; k < 6; k++) begin
            crc = crc ^ {8'h00, frame[k]};
            for (int b = 0; b < 8; b++) begin
               if (crc[0]) begin
                  crc = (crc >> 1) ^ ModbusCrcPoly;
               end else begin
                  crc = crc >> 1;
               end
            end
         end
         frame[6] = crc[7:0];
         frame[7] = crc[15:8];
         for (int k = 0; k < 8; k++) begin
            octet.data = frame[k];
            octet.last = (k == 7);
            expected_octets.push_back(octet);
         end
      endfunction

      function void check_octet(logic [7:0] data, logic last);
         frame_octet_type want;
         if (expected_octets.size() == 0) begin
            $display("%0t: unexpected frame byte: expected none, actual %02h last %0b",
                     $time, data, last);
            mismatches++;
            return;
         end
         want = expected_octets.pop_front();
         if (data !== want.data) begin
            $display("%0t: frame byte: expected %02h, actual %02h", $time, want.data, data);
            mismatches++;
         end
         if (last !== want.last) begin
            $display("%0t: last flag: expected %0b, actual %0b", $time, want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic req_tuser;
   logic [31:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   frame_scoreboard sb;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_cycles;

   modbus_rtu_request_framer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

   // The receiver either serves a requested stall or stalls at random.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_octet(rsp_tdata, rsp_tlast);
      end
   end

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: pick_word = 16'h0000;
         1: pick_word = 16'hFFFF;
         default: pick_word = 16'($urandom);
      endcase
   endfunction

   // Entered and left just after a falling edge.
   task automatic send_request(input logic act, input logic [15:0] reg_addr,
                               input logic [15:0] reg_val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = act;
      req_tdata = {reg_val, reg_addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(act, reg_addr, reg_val);
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = 32'b0;
   endtask

   task automatic write_csr(input logic [2:0] ofs, input logic [31:0] wdata);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = ofs;
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (ofs == SlaveAddrOfs) begin
         sb.set_dev_address(wdata[7:0]);
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_requests(input int count);
      for (int i = 0; i < count; i++) begin
         send_request($urandom_range(0, 1) ? ActWrite : ActRead, pick_word(), pick_word());
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = 32'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 3'b0;
      csr_pwdata = 32'b0;
      hold_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 30;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Default slave address, both operations at the field extremes and with alternating bit patterns.
      send_request(ActRead, 16'h0000, 16'h0000);
      send_request(ActRead, 16'hFFFF, 16'hFFFF);
      send_request(ActWrite, 16'h0000, 16'h0000);
      send_request(ActWrite, 16'hFFFF, 16'hFFFF);
      send_request(ActWrite, 16'h5555, 16'hAAAA);
      send_request(ActRead, 16'hAAAA, 16'h5555);
      wait_drained();

      write_csr(SlaveAddrOfs, 32'h0000_0000);
      send_request(ActRead, 16'h1234, 16'hBEEF);
      send_request(ActWrite, 16'h00FF, 16'hFF00);
      wait_drained();

      write_csr(SlaveAddrOfs, 32'd247);
      send_request(ActWrite, 16'hFF00, 16'h00FF);
      send_request(ActRead, 16'h8001, 16'h0000);
      wait_drained();

      // Addresses above the Modbus range pass unchecked; upper data bits are dropped.
      write_csr(SlaveAddrOfs, 32'hFFFF_FFFF);
      send_request(ActRead, 16'h0001, 16'h0001);
      send_request(ActWrite, 16'h7FFF, 16'h8000);
      wait_drained();

      write_csr(SlaveAddrOfs, 32'hA5A5_A5F8);
      send_request(ActWrite, 16'hC3C3, 16'h3C3C);
      wait_drained();

      // A write to an unmapped offset must leave the slave address alone.
      write_csr(UnusedOfs, 32'h0000_0055);
      send_request(ActRead, 16'h4242, 16'hFFFF);
      send_request(ActWrite, 16'h0102, 16'h0304);
      wait_drained();

      write_csr(SlaveAddrOfs, 32'($urandom_range(0, 255)));
      send_idle_pct = 14;
      recv_idle_pct = 86;
      send_random_requests(60);
      wait_drained();

      write_csr(SlaveAddrOfs, 32'($urandom_range(0, 255)));
      send_idle_pct = 86;
      recv_idle_pct = 14;
      send_random_requests(30);
      wait_drained();
      send_random_requests(30);
      wait_drained();

      write_csr(SlaveAddrOfs, 32'($urandom_range(0, 255)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 200;
      send_random_requests(60);
      wait_drained();

      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
